/* hw/rtl/sps_pkg.sv */
package sps_pkg;

    localparam int POS_W    = 32;
    localparam int PERIOD_W = 24;
    localparam int ELAPSED_W = 20;
    // Hold time stays below period + elapsed, so one bit over the period width covers it.
    localparam int HOLD_W   = PERIOD_W + 1;
    localparam int COIL_W   = 4;
    localparam int PHASE_W  = 2;

    localparam logic [PERIOD_W-1:0] IDLE_PERIOD_US  = PERIOD_W'(25000);
    localparam logic [PHASE_W-1:0]  LAST_PHASE      = PHASE_W'(3);
    localparam logic [PHASE_W-1:0]  IDLE_PHASE      = PHASE_W'(1);
    localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = PERIOD_W'(2000);
    localparam logic [COIL_W-1:0]   COILS_OFF       = '0;

    typedef enum logic [2:0] {
        REQ_TICK      = 3'd0,
        REQ_MOVE_TO   = 3'd1,
        REQ_MOVE_REL  = 3'd2,
        REQ_STEP_FWD  = 3'd3,
        REQ_STEP_BACK = 3'd4,
        REQ_GO_HOME   = 3'd5,
        REQ_STOP      = 3'd6
    } sps_req_kind_t;

    typedef enum logic [1:0] {
        CFG_MOTOR_KIND    = 2'd0,
        CFG_STEP_PERIOD   = 2'd1,
        CFG_DRIVE_ENABLE  = 2'd2,
        CFG_HOME_POSITION = 2'd3
    } sps_cfg_reg_t;

    typedef struct packed {
        logic [2:0]             req_type;
        logic [ELAPSED_W-1:0]   elapsed_us;
        logic signed [POS_W-1:0] position_arg;
    } sps_req_t;

    typedef struct packed {
        logic                    at_target;
        logic [COIL_W-1:0]       coil_pattern;
        logic signed [POS_W-1:0] position_now;
        logic                    move_done_event;
    } sps_res_t;

    typedef struct packed {
        logic                    motor_kind;
        logic [PERIOD_W-1:0]     step_period_us;
        logic                    drive_enable;
        logic signed [POS_W-1:0] home_position;
    } sps_cfg_t;

    // Full-step coil pattern for a phase; bipolar energizes two coils at once.
    function automatic logic [COIL_W-1:0] coil_for(input logic bipolar,
                                                   input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] pat;
        pat = COILS_OFF;
        if (bipolar)
        begin
            case (phase)
                2'd0:    pat = 4'h5;
                2'd1:    pat = 4'h9;
                2'd2:    pat = 4'hA;
                2'd3:    pat = 4'h6;
                default: pat = COILS_OFF;
            endcase
        end
        else
        begin
            case (phase)
                2'd0:    pat = 4'h1;
                2'd1:    pat = 4'h2;
                2'd2:    pat = 4'h4;
                2'd3:    pat = 4'h8;
                default: pat = COILS_OFF;
            endcase
        end
        return pat;
    endfunction

endpackage

/* hw/rtl/sps_req_if.sv */
interface sps_req_if
    import sps_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [2:0]              req_type;
    logic [ELAPSED_W-1:0]    elapsed_us;
    logic signed [POS_W-1:0] position_arg;

    modport source (output valid, output req_type, output elapsed_us,
                    output position_arg, input ready);
    modport sink   (input valid, input req_type, input elapsed_us,
                    input position_arg, output ready);
endinterface

/* hw/rtl/sps_res_if.sv */
interface sps_res_if
    import sps_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    at_target;
    logic [COIL_W-1:0]       coil_pattern;
    logic signed [POS_W-1:0] position_now;
    logic                    move_done_event;

    modport source (output valid, output at_target, output coil_pattern,
                    output position_now, output move_done_event, input ready);
    modport sink   (input valid, input at_target, input coil_pattern,
                    input position_now, input move_done_event, output ready);
endinterface

/* hw/rtl/sps_cfg_if.sv */
interface sps_cfg_if
    import sps_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* hw/rtl/sps_cfg_regs.sv */
module sps_cfg_regs
    import sps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sps_cfg_if.sink   cfg,
    output sps_cfg_t  cfg_val
);

    sps_cfg_t cfg_reg;
    sps_cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_val   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (sps_cfg_reg_t'(cfg.index))
                CFG_MOTOR_KIND:    cfg_next.motor_kind     = cfg.wdata[0];
                CFG_STEP_PERIOD:   cfg_next.step_period_us = cfg.wdata[PERIOD_W-1:0];
                CFG_DRIVE_ENABLE:  cfg_next.drive_enable   = cfg.wdata[0];
                CFG_HOME_POSITION: cfg_next.home_position  = $signed(cfg.wdata[POS_W-1:0]);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motor_kind     <= 1'b0;
            cfg_reg.step_period_us <= STEP_PERIOD_RST;
            cfg_reg.drive_enable   <= 1'b1;
            cfg_reg.home_position  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hw/rtl/sps_in_stage.sv */
module sps_in_stage
    import sps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sps_req_if.sink   req,
    input  logic      advance,
    output logic      item_valid,
    output sps_req_t  item
);

    logic     valid_reg;
    logic     valid_next;
    sps_req_t item_reg;
    logic     load;

    // Take a new item whenever the register is empty or drains this cycle.
    assign req.ready  = !valid_reg || advance;
    assign load       = req.valid && req.ready;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.req_type     <= req.req_type;
            item_reg.elapsed_us   <= req.elapsed_us;
            item_reg.position_arg <= req.position_arg;
        end
    end

endmodule

/* hw/rtl/sps_step_core.sv */
module sps_step_core
    import sps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  sps_req_t  item,
    input  sps_cfg_t  cfg_val,
    output sps_res_t  result
);

    logic signed [POS_W-1:0] position_reg, position_next;
    logic signed [POS_W-1:0] target_reg, target_next;
    logic [PHASE_W-1:0]      phase_reg, phase_next;
    logic [HOLD_W-1:0]       hold_reg, hold_next;
    logic [PERIOD_W-1:0]     period_reg, period_next;
    logic [COIL_W-1:0]       coil_reg, coil_next;
    logic                    finished_reg, finished_next;
    logic                    halted_reg, halted_next;
    logic                    status_reg, status_next;
    logic                    event_flag;
    logic                    poll_due;
    logic                    on_target;
    logic                    step_back;

    assign poll_due  = hold_reg >= {1'b0, period_reg};
    assign on_target = target_reg == position_reg;
    assign step_back = target_reg < position_reg;

    always_comb
    begin
        position_next = position_reg;
        target_next   = target_reg;
        phase_next    = phase_reg;
        hold_next     = hold_reg;
        period_next   = period_reg;
        coil_next     = coil_reg;
        finished_next = finished_reg;
        halted_next   = halted_reg;
        status_next   = status_reg;
        event_flag    = 1'b0;

        case (sps_req_kind_t'(item.req_type))
            REQ_TICK:
            begin
                if (poll_due)
                begin
                    status_next = on_target;
                    hold_next   = '0;
                    if (!on_target)
                    begin
                        period_next   = cfg_val.step_period_us;
                        finished_next = 1'b0;
                        if (step_back)
                        begin
                            phase_next    = (phase_reg == '0) ? LAST_PHASE
                                                              : phase_reg - PHASE_W'(1);
                            position_next = position_reg - POS_W'(1);
                        end
                        else
                        begin
                            phase_next    = (phase_reg == LAST_PHASE) ? '0
                                                                      : phase_reg + PHASE_W'(1);
                            position_next = position_reg + POS_W'(1);
                        end
                        if (cfg_val.drive_enable)
                        begin
                            coil_next = coil_for(cfg_val.motor_kind, phase_next);
                        end
                    end
                    else
                    begin
                        // Idle: with drive enabled, toggle between coils off and the hold pattern.
                        if (cfg_val.drive_enable)
                        begin
                            phase_next  = IDLE_PHASE;
                            period_next = IDLE_PERIOD_US;
                            coil_next   = (coil_reg != COILS_OFF) ? COILS_OFF
                                        : coil_for(cfg_val.motor_kind, IDLE_PHASE);
                        end
                        if (!finished_reg)
                        begin
                            event_flag    = !halted_reg;
                            halted_next   = 1'b0;
                            finished_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    hold_next = hold_reg + HOLD_W'(item.elapsed_us);
                end
            end
            REQ_MOVE_TO:
            begin
                finished_next = 1'b0;
                halted_next   = 1'b0;
                target_next   = item.position_arg;
            end
            REQ_MOVE_REL:
            begin
                finished_next = 1'b0;
                halted_next   = 1'b0;
                target_next   = position_reg + item.position_arg;
            end
            REQ_STEP_FWD:
            begin
                target_next = target_reg + POS_W'(1);
            end
            REQ_STEP_BACK:
            begin
                target_next = target_reg - POS_W'(1);
            end
            REQ_GO_HOME:
            begin
                halted_next = 1'b0;
                target_next = cfg_val.home_position;
            end
            REQ_STOP:
            begin
                target_next   = '0;
                position_next = '0;
                halted_next   = 1'b1;
            end
            default:
            begin
                event_flag = 1'b0;
            end
        endcase
    end

    assign result.at_target       = status_next;
    assign result.coil_pattern    = coil_next;
    assign result.position_now    = position_next;
    assign result.move_done_event = event_flag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            target_reg   <= '0;
            phase_reg    <= '0;
            hold_reg     <= '0;
            period_reg   <= STEP_PERIOD_RST;
            coil_reg     <= COILS_OFF;
            finished_reg <= 1'b0;
            halted_reg   <= 1'b1;
            status_reg   <= 1'b0;
        end
        else if (advance)
        begin
            position_reg <= position_next;
            target_reg   <= target_next;
            phase_reg    <= phase_next;
            hold_reg     <= hold_next;
            period_reg   <= period_next;
            coil_reg     <= coil_next;
            finished_reg <= finished_next;
            halted_reg   <= halted_next;
            status_reg   <= status_next;
        end
    end

endmodule

/* hw/rtl/sps_out_stage.sv */
module sps_out_stage
    import sps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  sps_res_t  result,
    output logic      space,
    sps_res_if.source res
);

    logic     valid_reg;
    logic     valid_next;
    sps_res_t res_reg;

    assign space      = !valid_reg || res.ready;
    assign valid_next = load ? 1'b1 : (res.ready ? 1'b0 : valid_reg);

    assign res.valid           = valid_reg;
    assign res.at_target       = res_reg.at_target;
    assign res.coil_pattern    = res_reg.coil_pattern;
    assign res.position_now    = res_reg.position_now;
    assign res.move_done_event = res_reg.move_done_event;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

endmodule

/* hw/rtl/stepper_position_sequencer_core.sv */
// Full-step position sequencer for a four-coil stepper. Each transfer on req is either a
// tick carrying elapsed microseconds or a command (move to, move by, step forward/back,
// go home, stop), and each one yields exactly one transfer on res with the polled
// at-target status, the coil drive bits, the position and a one-shot move-done pulse.
// Ticks accumulate time; the tick that finds the active period reached polls the motor,
// steps one phase toward the target, or, with drive enabled, toggles the idle hold pattern
// on a 25000 us period. An item passes through the input register and then the result
// register, and a new item is taken every cycle while res keeps up; the state update for
// one item compares target and position as signed 32-bit values and steps by one.
// Configuration writes on cfg take effect on the next cycle and are meant to be issued
// only while no item is in flight; a new step period applies from the next step taken.
module stepper_position_sequencer_core
    import sps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sps_req_if.sink   req,
    sps_res_if.source res,
    sps_cfg_if.sink   cfg
);

    sps_cfg_t cfg_val;
    sps_req_t item;
    sps_res_t result;
    logic     item_valid;
    logic     space;
    logic     advance;

    // Move the held item through the step logic when the result register is free or drains.
    assign advance = item_valid && space;

    sps_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    sps_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Motor state lives here and advances once per item.
    sps_step_core u_step_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .cfg_val (cfg_val),
        .result  (result)
    );

    sps_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .result (result),
        .space  (space),
        .res    (res)
    );

endmodule

/* hw/rtl/sps_checker.sv */
module sps_checker
    import sps_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    res_valid,
    input logic                    res_ready,
    input logic                    at_target,
    input logic [COIL_W-1:0]       coil_pattern,
    input logic signed [POS_W-1:0] position_now,
    input logic                    move_done_event
);

    // A completion pulse only comes from a poll that found the target.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && move_done_event |-> at_target)
        else $error("move_done_event without at_target");

    // Coils show off, or a legal full-step pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (coil_pattern == 4'h0 || coil_pattern == 4'h1 ||
                       coil_pattern == 4'h2 || coil_pattern == 4'h4 ||
                       coil_pattern == 4'h8 || coil_pattern == 4'h5 ||
                       coil_pattern == 4'h9 || coil_pattern == 4'hA ||
                       coil_pattern == 4'h6))
        else $error("illegal coil pattern");

    // No result is offered in the cycle after an edge seen in reset.
    assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid during reset");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(position_now)
                                    && $stable(coil_pattern))
        else $error("stalled result changed");

endmodule

bind stepper_position_sequencer_core sps_checker u_sps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .at_target       (res.at_target),
    .coil_pattern    (res.coil_pattern),
    .position_now    (res.position_now),
    .move_done_event (res.move_done_event)
);

/* bench/stepper_position_sequencer_core_tb.sv */
`timescale 1ns / 100ps

module stepper_position_sequencer_core_tb;
    import sps_pkg::*;

    // req_type 7 has no command behind it; the block must report state and change nothing
    localparam logic [2:0]           REQ_UNKNOWN  = 3'd7;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = '1;
    localparam int                   RESET_CYCLES = 12;
    localparam int                   IDLE_PCT     = 17;
    // Window of accepted items during which neither side inserts random gaps or back-pressure
    localparam int                   CALM_FIRST   = 500;
    localparam int                   CALM_LAST    = 800;
    localparam int                   CYCLE_LIMIT  = 400000;
    localparam int                   PRINT_CAP    = 100;
    localparam int                   DRAIN_CYCLES = 4;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sps_req_if req ();
    sps_res_if res ();
    sps_cfg_if cfg ();

    // Bench-side drive registers; the initializers keep every block input known from time 0
    logic         req_valid_q = 1'b0;
    sps_req_t     req_item_q  = '0;
    logic         res_ready_q = 1'b0;
    logic         cfg_valid_q = 1'b0;
    sps_cfg_reg_t cfg_index_q = CFG_MOTOR_KIND;
    logic [31:0]  cfg_wdata_q = '0;

    assign req.valid        = req_valid_q;
    assign req.req_type     = req_item_q.req_type;
    assign req.elapsed_us   = req_item_q.elapsed_us;
    assign req.position_arg = req_item_q.position_arg;
    assign res.ready        = res_ready_q;
    assign cfg.valid        = cfg_valid_q;
    assign cfg.index        = cfg_index_q;
    assign cfg.wdata        = cfg_wdata_q;

    stepper_position_sequencer_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res),
        .cfg   (cfg)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Items waiting to be offered on req, and status reports owed on res
    sps_req_t    req_backlog [$];
    sps_res_t    reports_due [$];
    int          items_taken   = 0;
    int          results_seen  = 0;
    int          error_count   = 0;
    int          cycle_count   = 0;
    int unsigned tick_span     = 2000;
    sps_res_t    predicted;

    // Shadow of the register file, at reset values
    sps_cfg_t shadow_cfg = '{1'b0, STEP_PERIOD_RST, 1'b1, 32'sd0};

    // Shadow of the motor state, at reset values
    logic signed [POS_W-1:0] motor_pos        = '0;
    logic signed [POS_W-1:0] motor_target     = '0;
    logic [PHASE_W-1:0]      motor_phase      = '0;
    logic [31:0]             hold_us          = '0;
    logic [PERIOD_W-1:0]     live_period_us   = STEP_PERIOD_RST;
    logic [COIL_W-1:0]       coil_drive       = COILS_OFF;
    logic                    move_closed      = 1'b0;
    logic                    halt_latch       = 1'b1;
    logic                    polled_at_target = 1'b0;

    // Full-step pattern: unipolar walks one coil, bipolar energizes a coil pair
    function automatic logic [COIL_W-1:0] coils_at(input logic bipolar,
                                                   input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] one_coil;
        logic [COIL_W-1:0] two_coils;
        one_coil = COIL_W'(1) << phase;
        case (phase)
            2'd0:    two_coils = 4'h5;
            2'd1:    two_coils = 4'h9;
            2'd2:    two_coils = 4'hA;
            default: two_coils = 4'h6;
        endcase
        return bipolar ? two_coils : one_coil;
    endfunction

    // A poll: latch the at-target status, then step toward target or run the idle hold
    task automatic poll_motor(output logic pulse);
        pulse            = 1'b0;
        polled_at_target = (motor_target == motor_pos);
        hold_us          = '0;
        if (!polled_at_target)
        begin
            // A new step period only takes hold here, on a step
            live_period_us = shadow_cfg.step_period_us;
            move_closed    = 1'b0;
            if (motor_target < motor_pos)
            begin
                motor_phase = motor_phase - 1'b1;
                motor_pos   = motor_pos - 32'sd1;
            end
            else
            begin
                motor_phase = motor_phase + 1'b1;
                motor_pos   = motor_pos + 32'sd1;
            end
            if (shadow_cfg.drive_enable)
                coil_drive = coils_at(shadow_cfg.motor_kind, motor_phase);
        end
        else
        begin
            // Idle hold: toggle between all-off and the idle phase pattern on the slow period
            if (shadow_cfg.drive_enable)
            begin
                motor_phase    = IDLE_PHASE;
                live_period_us = IDLE_PERIOD_US;
                if (coil_drive != COILS_OFF)
                    coil_drive = COILS_OFF;
                else
                    coil_drive = coils_at(shadow_cfg.motor_kind, IDLE_PHASE);
            end
            // First idle poll after a move closes it; a halted motor closes silently
            if (!move_closed)
            begin
                pulse       = !halt_latch;
                halt_latch  = 1'b0;
                move_closed = 1'b1;
            end
        end
    endtask

    // Apply one accepted item to the shadow motor and form the report it owes
    task automatic advance_motor(input sps_req_t item, output sps_res_t report);
        logic        pulse;
        logic [32:0] hold_sum;
        pulse = 1'b0;
        case (item.req_type)
            REQ_TICK:
            begin
                if (hold_us >= 32'(live_period_us))
                    poll_motor(pulse);
                else
                begin
                    // The tick that polls discards its own time; others accumulate, saturating
                    hold_sum = {1'b0, hold_us} + 33'(item.elapsed_us);
                    hold_us  = hold_sum[32] ? '1 : hold_sum[31:0];
                end
            end
            REQ_MOVE_TO:
            begin
                move_closed  = 1'b0;
                halt_latch   = 1'b0;
                motor_target = item.position_arg;
            end
            REQ_MOVE_REL:
            begin
                move_closed  = 1'b0;
                halt_latch   = 1'b0;
                motor_target = motor_pos + item.position_arg;
            end
            REQ_STEP_FWD:
                motor_target = motor_target + 32'sd1;
            REQ_STEP_BACK:
                motor_target = motor_target - 32'sd1;
            REQ_GO_HOME:
            begin
                halt_latch   = 1'b0;
                motor_target = shadow_cfg.home_position;
            end
            REQ_STOP:
            begin
                motor_target = '0;
                motor_pos    = '0;
                halt_latch   = 1'b1;
            end
            default: ;
        endcase
        report.at_target       = polled_at_target;
        report.coil_pattern    = coil_drive;
        report.position_now    = motor_pos;
        report.move_done_event = pulse;
    endtask

    // Random back-pressure and gaps, suppressed inside the calm window
    function automatic logic skip_cycle();
        if (items_taken >= CALM_FIRST && items_taken < CALM_LAST)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("mismatch on result %0d: %s", results_seen, what);
    endtask

    // Mostly ticks that drive short moves to completion, plus commands and noise
    function automatic sps_req_t random_item();
        sps_req_t    item;
        int unsigned pick;
        int          offset;
        item.req_type     = REQ_TICK;
        item.elapsed_us   = ELAPSED_W'($urandom());
        item.position_arg = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            item.req_type = REQ_TICK;
            case ($urandom_range(0, 9))
                0, 1:       item.elapsed_us = '0;
                2:          item.elapsed_us = ELAPSED_MAX;
                3, 4, 5, 6: item.elapsed_us = ELAPSED_W'($urandom_range(0, tick_span));
                default:    ;
            endcase
        end
        else if (pick < 70)
        begin
            // Keep absolute targets near home so moves finish and idle polls follow
            offset            = $urandom_range(0, 80);
            item.req_type     = REQ_MOVE_TO;
            item.position_arg = POS_W'(offset - 40);
        end
        else if (pick < 78)
        begin
            offset            = $urandom_range(0, 16);
            item.req_type     = REQ_MOVE_REL;
            item.position_arg = POS_W'(offset - 8);
        end
        else if (pick < 83)
            item.req_type = REQ_STEP_FWD;
        else if (pick < 88)
            item.req_type = REQ_STEP_BACK;
        else if (pick < 91)
            item.req_type = REQ_GO_HOME;
        else if (pick < 94)
            item.req_type = REQ_STOP;
        else if (pick < 97)
            // Full-range argument: far targets and wrapping relative sums
            item.req_type = pick[0] ? REQ_MOVE_TO : REQ_MOVE_REL;
        else
            item.req_type = REQ_UNKNOWN;
        return item;
    endfunction

    task automatic queue_item(input logic [2:0] kind, input logic [ELAPSED_W-1:0] elapsed,
                              input logic [POS_W-1:0] arg);
        sps_req_t item;
        item.req_type     = kind;
        item.elapsed_us   = elapsed;
        item.position_arg = arg;
        req_backlog.push_back(item);
    endtask

    // Hold off until the backlog is offered, every transfer on req is done
    // and every report owed has come back; sample on the falling edge
    task automatic wait_drained();
        @(negedge clk);
        while (req_backlog.size() != 0 || req_valid_q || reports_due.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // One register write; valid stays up so back-to-back writes never drop it
    task automatic write_reg(input sps_cfg_reg_t idx, input logic [31:0] value);
        cfg_index_q <= idx;
        cfg_wdata_q <= value;
        cfg_valid_q <= 1'b1;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            CFG_MOTOR_KIND:    shadow_cfg.motor_kind     = value[0];
            CFG_STEP_PERIOD:   shadow_cfg.step_period_us = value[PERIOD_W-1:0];
            CFG_DRIVE_ENABLE:  shadow_cfg.drive_enable   = value[0];
            CFG_HOME_POSITION: shadow_cfg.home_position  = value;
            default: ;
        endcase
    endtask

    // Write every register, then push a batch of random items and let it drain
    task automatic run_phase(input logic kind, input logic [PERIOD_W-1:0] period,
                             input logic enable, input logic [POS_W-1:0] home,
                             input int unsigned span, input int count);
        write_reg(CFG_MOTOR_KIND, 32'(kind));
        write_reg(CFG_STEP_PERIOD, 32'(period));
        write_reg(CFG_DRIVE_ENABLE, 32'(enable));
        write_reg(CFG_HOME_POSITION, home);
        cfg_valid_q <= 1'b0;
        tick_span = span;
        for (int n = 0; n < count; n++)
            req_backlog.push_back(random_item());
        wait_drained();
    endtask

    // Request driver: on an accepted transfer, predict the report; then refill or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid_q && req.ready)
            begin
                advance_motor(req_item_q, predicted);
                reports_due.push_back(predicted);
                items_taken++;
            end
            // Hold the item while it is stalled; advance only once the slot is free
            if (!req_valid_q || req.ready)
            begin
                if (req_backlog.size() != 0 && !skip_cycle())
                begin
                    req_item_q  <= req_backlog.pop_front();
                    req_valid_q <= 1'b1;
                end
                else
                    req_valid_q <= 1'b0;
            end
        end
    end

    // Result monitor: check each transfer on res against the oldest report owed
    always @(posedge clk)
    begin : check_reports
        sps_res_t owed;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                results_seen++;
                if (reports_due.size() == 0)
                    flag_error("result with no item outstanding");
                else
                begin
                    owed = reports_due.pop_front();
                    if (res.at_target !== owed.at_target)
                        flag_error($sformatf("at_target %0b, want %0b",
                                             res.at_target, owed.at_target));
                    if (res.coil_pattern !== owed.coil_pattern)
                        flag_error($sformatf("coil_pattern %h, want %h",
                                             res.coil_pattern, owed.coil_pattern));
                    if (res.position_now !== owed.position_now)
                        flag_error($sformatf("position_now %0d, want %0d",
                                             res.position_now, owed.position_now));
                    if (res.move_done_event !== owed.move_done_event)
                        flag_error($sformatf("move_done_event %0b, want %0b",
                                             res.move_done_event, owed.move_done_event));
                end
            end
            res_ready_q <= !skip_cycle();
        end
    end

    // Watchdog: count cycles and end a hung run
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("stepper_position_sequencer_core_tb: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, on reset register values (step period 2000)
        queue_item(REQ_UNKNOWN, ELAPSED_MAX, '1);
        queue_item(REQ_TICK, '0, '0);
        queue_item(REQ_TICK, ELAPSED_MAX, '0);
        // Idle poll while still halted from reset: hold pattern, no completion pulse
        queue_item(REQ_TICK, ELAPSED_MAX, '0);
        queue_item(REQ_MOVE_TO, ELAPSED_MAX, 32'sd2);
        queue_item(REQ_TICK, ELAPSED_MAX, '1);
        queue_item(REQ_TICK, '0, '0);
        queue_item(REQ_TICK, ELAPSED_MAX, '0);
        queue_item(REQ_TICK, '0, '0);
        queue_item(REQ_TICK, ELAPSED_MAX, '0);
        // Arrived: this poll raises the completion pulse
        queue_item(REQ_TICK, ELAPSED_MAX, '0);
        queue_item(REQ_MOVE_REL, '0, -32'sd1);
        queue_item(REQ_TICK, ELAPSED_MAX, '0);
        queue_item(REQ_TICK, ELAPSED_MAX, '0);
        queue_item(REQ_STEP_FWD, '0, '0);
        queue_item(REQ_STEP_BACK, '0, '0);
        queue_item(REQ_GO_HOME, '0, '0);
        // Signed extremes of the target, compared as signed
        queue_item(REQ_MOVE_TO, '0, 32'h7FFF_FFFF);
        queue_item(REQ_MOVE_TO, '0, 32'h8000_0000);
        queue_item(REQ_TICK, ELAPSED_MAX, '0);
        queue_item(REQ_TICK, ELAPSED_MAX, '0);
        // Relative move from position 0 to the top of the position range
        queue_item(REQ_MOVE_REL, '0, 32'h7FFF_FFFF);
        queue_item(REQ_STOP, '0, '1);
        queue_item(REQ_TICK, ELAPSED_MAX, '0);
        queue_item(REQ_TICK, ELAPSED_MAX, '0);
        wait_drained();

        // Random phases across register settings, extremes included
        run_phase(1'b1, '0, 1'b1, 32'sd5, 100, 200);
        run_phase(1'b0, 24'd1, 1'b0, 32'h8000_0000, 50, 180);
        run_phase(1'b1, '1, 1'b1, 32'h7FFF_FFFF, ELAPSED_MAX, 60);
        run_phase(1'b0, 24'd3000, 1'b1, -32'sd3, 6000, 220);
        run_phase(1'($urandom_range(0, 1)), PERIOD_W'($urandom_range(0, 5000)),
                  1'($urandom_range(0, 1)), 32'($urandom_range(0, 20)) - 32'd10,
                  5000, 250);
        run_phase(1'b0, STEP_PERIOD_RST, 1'b1, '0, 4000, 240);

        // Let any stray transfer show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && reports_due.size() == 0)
            $display("stepper_position_sequencer_core_tb: done, clean");
        else
            $display("stepper_position_sequencer_core_tb: done, errors");
        $finish;
    end

endmodule
